// ===== rtl/thm_pkg.sv =====
`timescale 1ns / 1ps
package thm_pkg;

	localparam int OVERSAMPLE_DEF = 10;

	// divider widths: dividend covers num + den/2, divisor covers den
	localparam int DVD_W = 58;
	localparam int DEN_W = 42;

	localparam logic signed [17:0] T_MIN     = -18'sd69888;
	localparam logic signed [17:0] T_MAX     = 18'sd65535;
	localparam logic [57:0]        Q_SAT     = 58'd135423;
	localparam logic [31:0]        LN2_Q24   = 32'd11629080;
	localparam logic [31:0]        K298      = 32'd298;
	localparam logic [31:0]        K298X256  = 32'd76288;

	typedef enum logic [2:0] {
		REG_HEAT_ON  = 3'd0,
		REG_HEAT_OFF = 3'd1,
		REG_BETA     = 3'd2,
		REG_LOAD     = 3'd3,
		REG_NOMINAL  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] sample;
		logic        adc_error;
	} in_item_t;

	typedef struct packed {
		logic signed [17:0] temperature;
		logic               heater_on;
		logic               status;
	} out_item_t;

	typedef struct packed {
		logic            start;
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

endpackage

// ===== rtl/thm_div.sv =====
`timescale 1ns / 1ps
module thm_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  thm_pkg::div_req_t       req,
	output logic                    done,
	output logic [thm_pkg::DVD_W-1:0] quotient
);
	import thm_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DVD_W-1:0] quo_q;
	logic [DEN_W:0]   sh;
	logic             fit;

	// restoring step: one quotient bit per cycle
	assign sh  = {rem_q, quo_q[DVD_W-1]};
	assign fit = sh >= {1'b0, den_q};

	// done rises the cycle after the last step, once the quotient holds every bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fit ? DEN_W'(sh - {1'b0, den_q}) : sh[DEN_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/thermistor_heater_thermostat.sv =====
`timescale 1ns / 1ps
// NTC thermistor thermometer with hysteresis heater control. Each accepted
// item is one ADC sample; OVERSAMPLE samples form a group, and a finished
// group yields one result item (temperature in 1/256 degC, heater state,
// status 0). A sample flagged adc_error drops the partial group and yields
// a result item with status 1 and the heater unchanged. A finished group
// runs in order through one shared 32x32 multiplier and one bit-serial
// divider: the mean (a reciprocal multiply that starts on the accepting
// edge), four log2 evaluations of a normalize loop and a squaring loop
// each, the multiply and sequencing steps, the final divide and the hand-off
// of the item. A zero mean goes straight to the hand-off; a denominator that
// is not positive skips the numerator multiply and the divide. Input is not
// taken while a group is being converted, nor while a result item waits and
// out_ready is low. Configuration is a plain write port, one register per
// cycle; write it only while no group is being converted.
module thermistor_heater_thermostat #(
	parameter int OVERSAMPLE = thm_pkg::OVERSAMPLE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  thm_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output thm_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data
);
	import thm_pkg::*;

	// mean by reciprocal multiply: exact for any 16-bit sum and group size up to 16
	localparam int          MEAN_SH  = 21;
	localparam logic [31:0] MEAN_RCP = 32'(((64'd1 << MEAN_SH) + 64'(OVERSAMPLE) - 64'd1)
		/ 64'(OVERSAMPLE));

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_MEAN = 13'b0000000000010,
		ST_DIV  = 13'b0000000000100,
		ST_NORM = 13'b0000000001000,
		ST_SQM  = 13'b0000000010000,
		ST_SQU  = 13'b0000000100000,
		ST_LNM  = 13'b0000001000000,
		ST_LNR  = 13'b0000010000000,
		ST_DENM = 13'b0000100000000,
		ST_DEN  = 13'b0001000000000,
		ST_NUMM = 13'b0010000000000,
		ST_NUM  = 13'b0100000000000,
		ST_DONE = 13'b1000000000000
	} state_t;

	// configuration registers
	logic signed [17:0] heat_on_q, heat_off_q;
	logic [15:0]        beta_q;
	logic [19:0]        load_q, nom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_on_q  <= 18'sd7680;
			heat_off_q <= 18'sd10240;
			beta_q     <= 16'd3950;
			load_q     <= 20'd22160;
			nom_q      <= 20'd100000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAT_ON:  heat_on_q  <= cfg_data[17:0];
				REG_HEAT_OFF: heat_off_q <= cfg_data[17:0];
				REG_BETA:     beta_q     <= cfg_data[15:0];
				REG_LOAD:     load_q     <= cfg_data;
				REG_NOMINAL:  nom_q      <= cfg_data;
				default:      ;
			endcase
		end
	end

	// zero beta, load and nominal registers act as one
	logic [15:0] beta_eff;
	logic [19:0] load_eff, nom_eff;
	assign beta_eff = (beta_q == '0) ? 16'd1 : beta_q;
	assign load_eff = (load_q == '0) ? 20'd1 : load_q;
	assign nom_eff  = (nom_q == '0) ? 20'd1 : nom_q;

	state_t             state_q;
	logic [15:0]        sum_q;
	logic [3:0]         count_q;
	logic               heater_q;
	logic [15:0]        m_q;
	logic [1:0]         idx_q;
	logic [31:0]        x_q;
	logic [4:0]         k_q;
	logic [23:0]        frac_q;
	logic [4:0]         sq_cnt_q;
	logic signed [31:0] lg_q;
	logic [31:0]        lnmag_q;
	logic [DEN_W-1:0]   den_q;
	logic signed [17:0] t_q;
	logic [63:0]        prod_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               accept, slot_free, last_sample;
	logic [15:0]        sum_new;
	logic [15:0]        m_mean;
	div_req_t           div_req;
	logic               div_done;
	logic [DVD_W-1:0]   quot;

	assign slot_free   = !out_valid_q || out_ready;
	assign in_ready    = (state_q == ST_IDLE) && slot_free;
	assign accept      = in_valid && in_ready;
	assign sum_new     = sum_q + 16'(in_item.sample);
	assign last_sample = count_q == 4'(OVERSAMPLE - 1);
	assign m_mean      = prod_q[MEAN_SH+15:MEAN_SH];

	// log2 operand: nominal, 4096-m, load, m
	logic [31:0] n4096, lg_opnd;
	always_comb begin
		n4096 = 32'd4096 - 32'(m_q);
		case (idx_q)
			2'd0:    lg_opnd = 32'(nom_eff);
			2'd1:    lg_opnd = (n4096 == '0) ? 32'd1 : n4096;
			2'd2:    lg_opnd = 32'(load_eff);
			default: lg_opnd = 32'(m_q);
		endcase
	end

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic        lg_neg;
	logic [31:0] lg_mag;
	assign lg_neg = lg_q < 0;
	assign lg_mag = lg_neg ? 32'(-lg_q) : 32'(lg_q);

	always_comb begin
		case (state_q)
			ST_IDLE: begin mul_a = 32'(sum_new);    mul_b = MEAN_RCP; end
			ST_LNM:  begin mul_a = lg_mag;          mul_b = LN2_Q24;  end
			ST_DENM: begin mul_a = lnmag_q;         mul_b = K298;     end
			ST_NUMM: begin mul_a = 32'(beta_eff);   mul_b = K298X256; end
			default: begin mul_a = x_q;             mul_b = x_q;      end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// squaring step result
	logic [32:0] sq_y;
	logic [23:0] frac_new;
	logic [28:0] lg_val;
	assign sq_y     = prod_q[63:31];
	assign frac_new = {frac_q[22:0], sq_y[32]};
	assign lg_val   = {k_q, frac_new};

	// denominator beta*2^24 - 298*ln
	logic signed [44:0] den_base, den_p, den_full;
	assign den_base = 45'(signed'({1'b0, beta_eff, 24'd0}));
	assign den_p    = 45'(signed'({1'b0, prod_q[43:0]}));
	assign den_full = lg_neg ? den_base + den_p : den_base - den_p;

	// hysteresis decision on the finished temperature
	logic heater_next;
	assign heater_next = (t_q < heat_on_q) ? 1'b1 :
		(t_q > heat_off_q) ? 1'b0 : heater_q;

	always_comb begin
		div_req = '0;
		if (state_q == ST_NUM) begin
			div_req.start    = 1'b1;
			div_req.dividend = {prod_q[33:0], 24'd0} + DVD_W'(den_q >> 1);
			div_req.divisor  = den_q;
		end
	end

	thm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			heater_q    <= 1'b0;
			idx_q       <= '0;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_item.adc_error) begin
							// drop the partial group, report the error
							sum_q       <= '0;
							count_q     <= '0;
							out_valid_q <= 1'b1;
						end else if (last_sample) begin
							sum_q   <= '0;
							count_q <= '0;
							state_q <= ST_MEAN;
						end else begin
							sum_q   <= sum_new;
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_MEAN: begin
					if (m_mean == '0) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_NORM: begin
					if (x_q[31]) begin
						sq_cnt_q <= '0;
						state_q  <= ST_SQM;
					end
				end
				ST_SQM: state_q <= ST_SQU;
				ST_SQU: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 5'd23) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q == 2'd3) ? ST_LNM : ST_NORM;
					end else begin
						state_q <= ST_SQM;
					end
				end
				ST_LNM:  state_q <= ST_LNR;
				ST_LNR:  state_q <= ST_DENM;
				ST_DENM: state_q <= ST_DEN;
				ST_DEN: begin
					state_q <= (den_full <= 0) ? ST_DONE : ST_NUMM;
				end
				ST_NUMM: state_q <= ST_NUM;
				ST_NUM:  state_q <= ST_DIV;
				ST_DONE: begin
					if (slot_free) begin
						heater_q    <= heater_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && in_item.adc_error) begin
					out_q.temperature <= '0;
					out_q.heater_on   <= heater_q;
					out_q.status      <= 1'b1;
				end
			end
			ST_MEAN: begin
				m_q  <= m_mean;
				t_q  <= T_MIN;
				lg_q <= '0;
				x_q  <= 32'(nom_eff);
				k_q  <= 5'd31;
			end
			ST_DIV: begin
				if (div_done) begin
					t_q <= (quot > Q_SAT) ? T_MAX : 18'(quot[17:0] + T_MIN);
				end
			end
			ST_NORM: begin
				if (!x_q[31]) begin
					x_q <= {x_q[30:0], 1'b0};
					k_q <= k_q - 1'b1;
				end
			end
			ST_SQU: begin
				frac_q <= frac_new;
				if (sq_cnt_q == 5'd23) begin
					// first two operands add, last two subtract
					lg_q <= idx_q[1] ? lg_q - 32'(lg_val) : lg_q + 32'(lg_val);
					// load the next log operand
					x_q <= (idx_q == 2'd0) ? ((n4096 == '0) ? 32'd1 : n4096) :
						(idx_q == 2'd1) ? 32'(load_eff) : 32'(m_q);
					k_q <= 5'd31;
				end else begin
					x_q <= sq_y[32] ? sq_y[32:1] : sq_y[31:0];
				end
			end
			ST_LNR: lnmag_q <= 32'((prod_q + 64'h0080_0000) >> 24);
			ST_DEN: begin
				den_q <= den_full[DEN_W-1:0];
				t_q   <= (den_full == 0) ? T_MAX : T_MIN;
			end
			ST_DONE: begin
				if (slot_free) begin
					out_q.temperature <= t_q;
					out_q.heater_on   <= heater_next;
					out_q.status      <= 1'b0;
				end
			end
			default: ;
		endcase
		if (state_q == ST_SQM) begin
			frac_q <= (sq_cnt_q == '0) ? '0 : frac_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// lg_opnd mirrors the operand loaded into the log unit
	logic opnd_ok;
	assign opnd_ok = lg_opnd != '0;

	property p_div_in_div;
		@(posedge clk) disable iff (!arst_n) div_done |-> state_q == ST_DIV;
	endproperty
	assert property (p_div_in_div) else $error("divider finished outside divide state");

	property p_count_range;
		@(posedge clk) disable iff (!arst_n) count_q <= 4'(OVERSAMPLE - 1);
	endproperty
	assert property (p_count_range) else $error("sample count beyond group size");

	property p_done_emits;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_DONE && slot_free) |=> (out_valid_q && state_q == ST_IDLE);
	endproperty
	assert property (p_done_emits) else $error("finished group did not produce an item");

	property p_norm_operand;
		@(posedge clk) disable iff (!arst_n) state_q == ST_NORM |-> opnd_ok;
	endproperty
	assert property (p_norm_operand) else $error("log operand is zero");

endmodule
